// File: rtl/tsi_pkg.sv
// ============================================================================
// tsi_pkg: shared definitions for the snapshot interpolator
// Widths, register indexes, the snapshot record, the controller states and
// the command and status groups that pass between controller and datapath.
// ============================================================================
`default_nettype none

package tsi_pkg;

  // Ring and number formats.
  localparam int SNAP_DEPTH = 8;
  localparam int PTR_W      = $clog2(SNAP_DEPTH);
  localparam int CNT_W      = $clog2(SNAP_DEPTH + 1);
  localparam int FRAC_BITS  = 16;
  localparam int FRAC_W     = FRAC_BITS + 1;
  localparam int DIVCNT_W   = $clog2(FRAC_W);
  localparam int TIME_W     = 32;
  localparam int POS_W      = 32;
  localparam int RENDER_W   = TIME_W + 3;
  localparam int PROD_W     = (POS_W + 1) + (FRAC_W + 1);
  localparam int AXES       = 3;
  localparam int AXIS_W     = 2;

  // Configuration port.
  localparam int DELAY_W    = 20;
  localparam int SPAN_W     = 16;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_INTERP_DELAY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN     = CFG_IDX_W'(1);

  localparam logic [DELAY_W-1:0] INTERP_DELAY_RST = DELAY_W'(100000);
  localparam logic [SPAN_W-1:0]  MIN_SPAN_RST     = SPAN_W'(100);

  // Item function codes.
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Fraction of one in FRAC_BITS fractional bits.
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

  // One stored snapshot, as a single RAM word.
  typedef struct packed {
    logic [TIME_W-1:0] stime;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
  } snap_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEWEST,
    ST_LATCH,
    ST_RENDER,
    ST_FIRST,
    ST_WALK,
    ST_SETUP,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic push;
    logic start_query;
    logic rd_newest;
    logic latch_newest;
    logic idx_clear;
    logic idx_inc;
    logic calc_render;
    logic load_cur;
    logic take_bracket;
    logic div_setup;
    logic div_step;
    logic mul;
    logic add;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic hit;
    logic walk_last;
    logic short_span;
    logic div_last;
    logic axis_last;
    logic out_free;
  } status_t;

  // Ring slot of the snapshot at a given age, counted from the oldest.
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] oldest,
                                               input logic [CNT_W-1:0] age);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(oldest) + (CNT_W + 1)'(age);
    if (sum >= (CNT_W + 1)'(SNAP_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(SNAP_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Position component of a snapshot by axis number.
  function automatic logic [POS_W-1:0] axis_of(input snap_t s,
                                               input logic [AXIS_W-1:0] axis);
    logic [POS_W-1:0] v;
    case (axis)
      AXIS_W'(0): v = s.x;
      AXIS_W'(1): v = s.y;
      default:    v = s.z;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tsi_if.sv
// ============================================================================
// tsi_if: item channels of the snapshot interpolator
// Request channel (push or query) and response channel (position), each with
// valid/ready handshake.
// ============================================================================
`default_nettype none

interface tsi_req_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [tsi_pkg::TIME_W-1:0]       snap_time;
  logic signed [tsi_pkg::POS_W-1:0] pos_x;
  logic signed [tsi_pkg::POS_W-1:0] pos_y;
  logic signed [tsi_pkg::POS_W-1:0] pos_z;
  logic [tsi_pkg::TIME_W-1:0]       local_time;

  modport source (output valid, func, snap_time, pos_x, pos_y, pos_z, local_time,
                  input ready);
  modport sink (input valid, func, snap_time, pos_x, pos_y, pos_z, local_time,
                output ready);
endinterface

interface tsi_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             has_position;
  logic signed [tsi_pkg::POS_W-1:0] out_x;
  logic signed [tsi_pkg::POS_W-1:0] out_y;
  logic signed [tsi_pkg::POS_W-1:0] out_z;

  modport source (output valid, has_position, out_x, out_y, out_z, input ready);
  modport sink (input valid, has_position, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

// File: rtl/timestamped_snapshot_interpolator_core.sv
// Push: written to the ring at the accept edge; ready stays high.
// Query: an empty ring gives no position and a single snapshot gives its own position; otherwise
// the walk does one RAM read per bracket step, then a 17-step serial divider (skipped for a short
// span) computes the fraction and one shared multiplier mixes the three axes.
// One item is worked at a time; a finished result waits in an output register.
// Reset (synchronous, rst high) empties the ring and restores both config registers.
// ============================================================================
// timestamped_snapshot_interpolator_core: snapshot ring with linear interpolation
// Stores timestamped 3D positions and answers render-time position queries.
// ============================================================================
`default_nettype none

module timestamped_snapshot_interpolator_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  tsi_req_if.sink                             req,
  tsi_rsp_if.source                           rsp,
  input  wire logic                           cfg_we,
  input  wire logic [tsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsi_pkg::CFG_DATA_W-1:0] cfg_data
);

  tsi_pkg::cmd_t    cmd;
  tsi_pkg::status_t sts;
  logic             req_ready;

  assign req.ready = req_ready;

  // Sequencer.
  tsi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  tsi_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .snap_time    (req.snap_time),
    .pos_x        (req.pos_x),
    .pos_y        (req.pos_y),
    .pos_z        (req.pos_z),
    .local_time   (req.local_time),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .has_position (rsp.has_position),
    .out_x        (rsp.out_x),
    .out_y        (rsp.out_y),
    .out_z        (rsp.out_z),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

`default_nettype wire

// File: rtl/tsi_ram.sv
// ============================================================================
// tsi_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module tsi_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/tsi_ctrl.sv
// ============================================================================
// tsi_ctrl: sequencing controller of the snapshot interpolator
// Steps one query through newest read, render time, bracket walk, divide,
// per-axis mix and result hand-off. Pushes are written in the accept cycle.
// ============================================================================
`default_nettype none

module tsi_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire logic             req_func,
  output logic                  req_ready,
  input  wire tsi_pkg::status_t sts,
  output tsi_pkg::cmd_t         cmd
);

  tsi_pkg::state_t state;
  tsi_pkg::state_t state_next;
  logic            req_fire;

  assign req_fire = req_valid && req_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      tsi_pkg::ST_IDLE: begin
        if (req_fire && req_func == tsi_pkg::FUNC_QUERY) begin
          state_next = sts.count_zero ? tsi_pkg::ST_DONE : tsi_pkg::ST_NEWEST;
        end
      end
      tsi_pkg::ST_NEWEST: state_next = tsi_pkg::ST_LATCH;
      tsi_pkg::ST_LATCH: begin
        state_next = sts.count_one ? tsi_pkg::ST_DONE : tsi_pkg::ST_RENDER;
      end
      tsi_pkg::ST_RENDER: state_next = tsi_pkg::ST_FIRST;
      tsi_pkg::ST_FIRST:  state_next = tsi_pkg::ST_WALK;
      tsi_pkg::ST_WALK: begin
        if (sts.hit) begin
          state_next = tsi_pkg::ST_SETUP;
        end else if (sts.walk_last) begin
          state_next = tsi_pkg::ST_DONE;
        end
      end
      tsi_pkg::ST_SETUP: begin
        state_next = sts.short_span ? tsi_pkg::ST_MUL : tsi_pkg::ST_DIV;
      end
      tsi_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_next = tsi_pkg::ST_MUL;
        end
      end
      tsi_pkg::ST_MUL: state_next = tsi_pkg::ST_ADD;
      tsi_pkg::ST_ADD: begin
        state_next = sts.axis_last ? tsi_pkg::ST_DONE : tsi_pkg::ST_MUL;
      end
      tsi_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_next = tsi_pkg::ST_IDLE;
        end
      end
      default: state_next = tsi_pkg::ST_IDLE;
    endcase
  end

  // Output logic: handshake and datapath commands.
  always_comb begin
    req_ready = 1'b0;
    cmd       = '0;
    case (state)
      tsi_pkg::ST_IDLE: begin
        req_ready       = 1'b1;
        cmd.push        = req_fire && req_func == tsi_pkg::FUNC_PUSH;
        cmd.start_query = req_fire && req_func == tsi_pkg::FUNC_QUERY;
      end
      tsi_pkg::ST_NEWEST: cmd.rd_newest = 1'b1;
      tsi_pkg::ST_LATCH: begin
        cmd.latch_newest = 1'b1;
        cmd.idx_clear    = 1'b1;
      end
      tsi_pkg::ST_RENDER: begin
        cmd.calc_render = 1'b1;
        cmd.idx_inc     = 1'b1;
      end
      tsi_pkg::ST_FIRST: begin
        cmd.load_cur = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      tsi_pkg::ST_WALK: begin
        if (sts.hit) begin
          cmd.take_bracket = 1'b1;
        end else if (!sts.walk_last) begin
          cmd.load_cur = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      tsi_pkg::ST_SETUP: cmd.div_setup = 1'b1;
      tsi_pkg::ST_DIV:   cmd.div_step  = 1'b1;
      tsi_pkg::ST_MUL:   cmd.mul       = 1'b1;
      tsi_pkg::ST_ADD:   cmd.add       = 1'b1;
      tsi_pkg::ST_DONE:  cmd.load_out  = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/tsi_datapath.sv
// ============================================================================
// tsi_datapath: storage and arithmetic of the snapshot interpolator
// Snapshot ring in RAM, time tracking, render time, bracket compare,
// bit-serial fraction divider, shared per-axis multiplier and result register.
// ============================================================================
`default_nettype none

module tsi_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Configuration writes.
  input  wire logic                                 cfg_we,
  input  wire logic [tsi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [tsi_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Request payload.
  input  wire logic [tsi_pkg::TIME_W-1:0]           snap_time,
  input  wire logic signed [tsi_pkg::POS_W-1:0]     pos_x,
  input  wire logic signed [tsi_pkg::POS_W-1:0]     pos_y,
  input  wire logic signed [tsi_pkg::POS_W-1:0]     pos_z,
  input  wire logic [tsi_pkg::TIME_W-1:0]           local_time,
  // Response channel.
  output logic                                      rsp_valid,
  input  wire logic                                 rsp_ready,
  output logic                                      has_position,
  output logic signed [tsi_pkg::POS_W-1:0]          out_x,
  output logic signed [tsi_pkg::POS_W-1:0]          out_y,
  output logic signed [tsi_pkg::POS_W-1:0]          out_z,
  // Controller link.
  input  wire tsi_pkg::cmd_t                        cmd,
  output tsi_pkg::status_t                          sts
);

  // Configuration registers.
  logic [tsi_pkg::DELAY_W-1:0] interp_delay;
  logic [tsi_pkg::SPAN_W-1:0]  min_span;

  // Ring and time tracking.
  logic [tsi_pkg::CNT_W-1:0]   snap_count;
  logic [tsi_pkg::PTR_W-1:0]   oldest_ptr;
  logic [tsi_pkg::TIME_W-1:0]  latest_server;
  logic [tsi_pkg::TIME_W-1:0]  arrival_local;
  logic [tsi_pkg::TIME_W-1:0]  now_q;

  // Query working registers.
  logic signed [tsi_pkg::RENDER_W-1:0] render;
  tsi_pkg::snap_t                      cur;
  tsi_pkg::snap_t                      prev;
  logic [tsi_pkg::CNT_W-1:0]           idx;
  logic [tsi_pkg::TIME_W:0]            rem;
  logic [tsi_pkg::TIME_W-1:0]          dur;
  logic [tsi_pkg::FRAC_W-1:0]          quo;
  logic [tsi_pkg::DIVCNT_W-1:0]        div_cnt;
  logic signed [tsi_pkg::PROD_W-1:0]   prod;
  logic [tsi_pkg::AXIS_W-1:0]          axis;
  logic [tsi_pkg::POS_W-1:0]           res_pos [tsi_pkg::AXES];
  logic                                res_has;

  // RAM ports.
  logic                       ram_we;
  logic [tsi_pkg::PTR_W-1:0]  ram_waddr;
  tsi_pkg::snap_t             ram_wdata;
  logic [tsi_pkg::PTR_W-1:0]  ram_raddr;
  tsi_pkg::snap_t             ram_rdata;
  logic [tsi_pkg::CNT_W-1:0]  rd_age;
  logic                       ring_full;

  // Combinational helpers.
  logic signed [tsi_pkg::RENDER_W-1:0] ta_ext;
  logic signed [tsi_pkg::RENDER_W-1:0] tb_ext;
  logic signed [tsi_pkg::RENDER_W-1:0] num_ext;
  logic [tsi_pkg::TIME_W-1:0]          dur_w;
  logic                                div_ge;
  logic [tsi_pkg::TIME_W:0]            rem_sub;
  logic [tsi_pkg::FRAC_W-1:0]          frac;
  logic [tsi_pkg::POS_W-1:0]           a_k;
  logic [tsi_pkg::POS_W-1:0]           b_k;
  logic signed [tsi_pkg::POS_W:0]      diff;
  logic signed [tsi_pkg::PROD_W-1:0]   prod_sh;

  tsi_ram #(
    .WIDTH ($bits(tsi_pkg::snap_t)),
    .DEPTH (tsi_pkg::SNAP_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      interp_delay <= tsi_pkg::INTERP_DELAY_RST;
      min_span     <= tsi_pkg::MIN_SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tsi_pkg::REG_INTERP_DELAY: interp_delay <= cfg_data[tsi_pkg::DELAY_W-1:0];
        tsi_pkg::REG_MIN_SPAN:     min_span     <= cfg_data[tsi_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring write: a full ring overwrites the oldest entry.
  assign ring_full = snap_count == tsi_pkg::CNT_W'(tsi_pkg::SNAP_DEPTH);
  assign ram_we    = cmd.push;
  assign ram_waddr = ring_full ? oldest_ptr : tsi_pkg::slot_of(oldest_ptr, snap_count);
  assign ram_wdata = '{stime: snap_time, x: pos_x, y: pos_y, z: pos_z};

  // Ring read: the newest entry, or the walk index.
  assign rd_age    = cmd.rd_newest ? snap_count - tsi_pkg::CNT_W'(1) : idx;
  assign ram_raddr = tsi_pkg::slot_of(oldest_ptr, rd_age);

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_count <= '0;
      oldest_ptr <= '0;
    end else if (cmd.push) begin
      if (ring_full) begin
        oldest_ptr <= (oldest_ptr == tsi_pkg::PTR_W'(tsi_pkg::SNAP_DEPTH - 1)) ?
                      '0 : oldest_ptr + tsi_pkg::PTR_W'(1);
      end else begin
        snap_count <= snap_count + tsi_pkg::CNT_W'(1);
      end
    end
  end

  // Newest server time and its local arrival time.
  always_ff @(posedge clk) begin
    if (rst) begin
      latest_server <= '0;
      arrival_local <= '0;
    end else if (cmd.latch_newest && !sts.count_one && ram_rdata.stime > latest_server) begin
      latest_server <= ram_rdata.stime;
      arrival_local <= now_q;
    end
  end

  // Bracket compare of the held entry against the one just read.
  assign ta_ext  = $signed(tsi_pkg::RENDER_W'(cur.stime));
  assign tb_ext  = $signed(tsi_pkg::RENDER_W'(ram_rdata.stime));
  assign num_ext = render - $signed(tsi_pkg::RENDER_W'(prev.stime));
  assign dur_w   = cur.stime - prev.stime;

  // Divider step: restoring, one quotient bit per cycle.
  assign div_ge  = rem >= {1'b0, dur};
  assign rem_sub = div_ge ? rem - {1'b0, dur} : rem;
  assign frac    = (quo > tsi_pkg::FRAC_ONE) ? tsi_pkg::FRAC_ONE : quo;

  // Per-axis mix operands.
  assign a_k     = tsi_pkg::axis_of(prev, axis);
  assign b_k     = tsi_pkg::axis_of(cur, axis);
  assign diff    = $signed({b_k[tsi_pkg::POS_W-1], b_k}) - $signed({a_k[tsi_pkg::POS_W-1], a_k});
  assign prod_sh = prod >>> tsi_pkg::FRAC_BITS;

  // Query working registers.
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      now_q <= local_time;
    end
    if (cmd.calc_render) begin
      render <= $signed(tsi_pkg::RENDER_W'(latest_server))
              + $signed(tsi_pkg::RENDER_W'(now_q))
              - $signed(tsi_pkg::RENDER_W'(arrival_local))
              - $signed(tsi_pkg::RENDER_W'(interp_delay));
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + tsi_pkg::CNT_W'(1);
    end
    if (cmd.load_cur) begin
      cur <= ram_rdata;
    end else if (cmd.take_bracket) begin
      prev <= cur;
      cur  <= ram_rdata;
    end
    if (cmd.div_setup) begin
      dur     <= dur_w;
      rem     <= {1'b0, num_ext[tsi_pkg::TIME_W-1:0]};
      quo     <= (dur_w <= tsi_pkg::TIME_W'(min_span)) ? tsi_pkg::FRAC_ONE : '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= {rem_sub[tsi_pkg::TIME_W-1:0], 1'b0};
      quo     <= {quo[tsi_pkg::FRAC_W-2:0], div_ge};
      div_cnt <= div_cnt + tsi_pkg::DIVCNT_W'(1);
    end
    if (cmd.mul) begin
      prod <= diff * $signed({1'b0, frac});
    end
  end

  // Axis counter and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      axis    <= '0;
      res_has <= 1'b0;
    end else begin
      if (cmd.div_setup) begin
        axis <= '0;
      end else if (cmd.add) begin
        axis <= axis + tsi_pkg::AXIS_W'(1);
      end
      if (cmd.start_query) begin
        res_has <= 1'b0;
      end else if (cmd.latch_newest) begin
        res_has <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      res_pos[0] <= '0;
      res_pos[1] <= '0;
      res_pos[2] <= '0;
    end else if (cmd.latch_newest) begin
      res_pos[0] <= ram_rdata.x;
      res_pos[1] <= ram_rdata.y;
      res_pos[2] <= ram_rdata.z;
    end else if (cmd.add) begin
      res_pos[axis] <= a_k + prod_sh[tsi_pkg::POS_W-1:0];
    end
  end

  // Output register: holds a finished item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      has_position <= res_has;
      out_x        <= $signed(res_pos[0]);
      out_y        <= $signed(res_pos[1]);
      out_z        <= $signed(res_pos[2]);
    end
  end

  // Status back to the controller.
  assign sts.count_zero = snap_count == '0;
  assign sts.count_one  = snap_count == tsi_pkg::CNT_W'(1);
  assign sts.hit        = (ta_ext <= render) && (tb_ext >= render);
  assign sts.walk_last  = idx == snap_count;
  assign sts.short_span = dur_w <= tsi_pkg::TIME_W'(min_span);
  assign sts.div_last   = div_cnt == tsi_pkg::DIVCNT_W'(tsi_pkg::FRAC_W - 1);
  assign sts.axis_last  = axis == tsi_pkg::AXIS_W'(tsi_pkg::AXES - 1);
  assign sts.out_free   = !rsp_valid || rsp_ready;

endmodule

`default_nettype wire

// File: rtl/tsi_checker.sv
// ============================================================================
// tsi_checker: port-level checks of the snapshot interpolator
// Watches the request and response channels of the top level over time.
// ============================================================================
`default_nettype none

module tsi_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       req_valid,
  input wire logic                       req_ready,
  input wire logic                       req_func,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_ready,
  input wire logic                       rsp_has_position,
  input wire logic [tsi_pkg::POS_W-1:0]  rsp_x,
  input wire logic [tsi_pkg::POS_W-1:0]  rsp_y,
  input wire logic [tsi_pkg::POS_W-1:0]  rsp_z
);

  // A stalled result stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response valid dropped while stalled");

  // A stalled result keeps its payload.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_has_position) && $stable(rsp_x)
                                && $stable(rsp_y) && $stable(rsp_z))
    else $error("response payload changed while stalled");

  // An empty-ring answer carries a zero position.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_has_position |-> rsp_x == '0 && rsp_y == '0 && rsp_z == '0)
    else $error("no-position result with nonzero position");

  // A query occupies the block for at least the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func == tsi_pkg::FUNC_QUERY |=> !req_ready)
    else $error("request taken right after a query");

  // A new result only appears after the block was busy with a query.
  a_rsp_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result appeared without a query in progress");

endmodule

bind timestamped_snapshot_interpolator_core tsi_checker u_tsi_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_func         (req.func),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_has_position (rsp.has_position),
  .rsp_x            (rsp.out_x),
  .rsp_y            (rsp.out_y),
  .rsp_z            (rsp.out_z)
);

`default_nettype wire

// File: verif/timestamped_snapshot_interpolator_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// timestamped_snapshot_interpolator_core_tb: self-checking bench for the core
// Drives pushes and render queries through the request channel, predicts each
// position with a local model of the ring and compares every response item
// field by field. Register settings change between phases while idle.
// ============================================================================

module timestamped_snapshot_interpolator_core_tb;

  localparam int TIME_W     = tsi_pkg::TIME_W;
  localparam int POS_W      = tsi_pkg::POS_W;
  localparam int FRAC_BITS  = tsi_pkg::FRAC_BITS;
  localparam int SNAP_DEPTH = tsi_pkg::SNAP_DEPTH;
  localparam int DELAY_W    = tsi_pkg::DELAY_W;
  localparam int SPAN_W     = tsi_pkg::SPAN_W;
  localparam int CFG_IDX_W  = tsi_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = tsi_pkg::CFG_DATA_W;

  localparam int    DRAIN_CYCLES = 64;
  localparam longint TIME_TOP    = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] snap_time;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [TIME_W-1:0] local_time;
  } req_item_t;

  typedef struct packed {
    logic             has_position;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } pos_result_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_LONG, RX_TOGGLE} rx_mode_t;

  // Ring model and queue of predicted positions.
  class interp_scoreboard;
    localparam longint FRAC_UNIT = longint'(1) << FRAC_BITS;

    logic [TIME_W-1:0]  snap_t [SNAP_DEPTH];
    logic [POS_W-1:0]   snap_x [SNAP_DEPTH];
    logic [POS_W-1:0]   snap_y [SNAP_DEPTH];
    logic [POS_W-1:0]   snap_z [SNAP_DEPTH];
    int unsigned        count;
    int unsigned        oldest;
    logic [TIME_W-1:0]  latest;
    logic [TIME_W-1:0]  arrival;
    logic [DELAY_W-1:0] delay_reg;
    logic [SPAN_W-1:0]  span_reg;
    pos_result_t        expected_pos[$];
    int errors, n_push, n_query, n_mixed, n_span_one, n_newest, n_short;

    function new();
      count     = 0;
      oldest    = 0;
      latest    = '0;
      arrival   = '0;
      delay_reg = tsi_pkg::INTERP_DELAY_RST;
      span_reg  = tsi_pkg::MIN_SPAN_RST;
      errors    = 0;
      n_push    = 0;
      n_query   = 0;
      n_mixed   = 0;
      n_span_one = 0;
      n_newest  = 0;
      n_short   = 0;
    endfunction

    function int unsigned ring_slot(int unsigned age);
      return (oldest + age) % SNAP_DEPTH;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == tsi_pkg::REG_INTERP_DELAY) begin
        delay_reg = data[DELAY_W-1:0];
      end else begin
        span_reg = data[SPAN_W-1:0];
      end
    endfunction

    // Linear mix of one axis; negative steps round toward minus infinity.
    function logic [POS_W-1:0] blend(logic [POS_W-1:0] a_bits, logic [POS_W-1:0] b_bits,
                                     longint f);
      longint a, d, q;
      a = $signed(a_bits);
      d = $signed(b_bits) - a;
      if (d >= 0) begin
        q = (d * f) >>> FRAC_BITS;
      end else begin
        q = -((((-d) * f) + (FRAC_UNIT - 1)) >>> FRAC_BITS);
      end
      return POS_W'(a + q);
    endfunction

    // Applies an accepted item and queues the position a query must answer.
    function void note_item(req_item_t it);
      int unsigned s, nw, a, b;
      pos_result_t r;
      longint lt, nowl, arr, dl, render, ta, tb, dur, f;
      bit found;
      if (it.func == tsi_pkg::FUNC_PUSH) begin
        if (count >= SNAP_DEPTH) begin
          s = oldest;
          oldest = (oldest + 1) % SNAP_DEPTH;
        end else begin
          s = ring_slot(count);
          count++;
        end
        snap_t[s] = it.snap_time;
        snap_x[s] = it.pos_x;
        snap_y[s] = it.pos_y;
        snap_z[s] = it.pos_z;
        n_push++;
        return;
      end
      n_query++;
      r = '0;
      if (count == 0) begin
        n_short++;
        expected_pos.push_back(r);
        return;
      end
      nw = ring_slot(count - 1);
      r.has_position = 1'b1;
      r.x = snap_x[nw];
      r.y = snap_y[nw];
      r.z = snap_z[nw];
      if (count == 1) begin
        n_short++;
        expected_pos.push_back(r);
        return;
      end
      // Track the newest server time and when it was first seen locally.
      if (snap_t[nw] > latest) begin
        latest  = snap_t[nw];
        arrival = it.local_time;
      end
      lt     = latest;
      nowl   = it.local_time;
      arr    = arrival;
      dl     = delay_reg;
      render = lt + (nowl - arr) - dl;
      // Oldest adjacent pair that brackets the render time wins.
      found = 1'b0;
      for (int i = 0; i + 1 < int'(count) && !found; i++) begin
        a  = ring_slot(i);
        b  = ring_slot(i + 1);
        ta = snap_t[a];
        tb = snap_t[b];
        if (ta <= render && tb >= render) begin
          found = 1'b1;
          dur   = tb - ta;
          f     = FRAC_UNIT;
          if (dur > longint'(span_reg)) begin
            f = ((render - ta) << FRAC_BITS) / dur;
            if (f > FRAC_UNIT) begin
              f = FRAC_UNIT;
            end
          end else begin
            n_span_one++;
          end
          r.x = blend(snap_x[a], snap_x[b], f);
          r.y = blend(snap_y[a], snap_y[b], f);
          r.z = blend(snap_z[a], snap_z[b], f);
        end
      end
      if (found) begin
        n_mixed++;
      end else begin
        n_newest++;
      end
      expected_pos.push_back(r);
    endfunction

    function void report(string field, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      errors++;
    endfunction

    // Compares a response item with the oldest predicted position.
    function void check_result(pos_result_t got);
      pos_result_t want;
      if (expected_pos.size() == 0) begin
        $display("%0t: response item with no query outstanding: expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_pos.pop_front();
      if (got.has_position !== want.has_position) begin
        report("has_position", POS_W'(want.has_position), POS_W'(got.has_position));
      end
      if (got.x !== want.x) begin
        report("out_x", want.x, got.x);
      end
      if (got.y !== want.y) begin
        report("out_y", want.y, got.y);
      end
      if (got.z !== want.z) begin
        report("out_z", want.z, got.z);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsi_req_if req_ch();
  tsi_rsp_if rsp_ch();

  interp_scoreboard sb = new();

  int       burst_left = 0;
  int       n_items    = 0;
  int       n_settings = 0;
  longint   srv_clk;
  longint   loc_clk;
  rx_mode_t rx_mode    = RX_ALWAYS;
  int       rx_left    = 0;
  logic [7:0] rx_tick  = '0;

  timestamped_snapshot_interpolator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response stalls follow a pattern whose mode changes at random.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(40, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: rsp_ch.ready <= 1'b1;
      RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 2) != 0);
      RX_LONG:   rsp_ch.ready <= (rx_tick[3:0] == 4'hF);
      default:   rsp_ch.ready <= rx_tick[0];
    endcase
    rx_tick <= rx_tick + 8'd1;
  end

  // Every accepted response item is checked against the prediction.
  always @(posedge clk) begin : rsp_monitor
    pos_result_t got;
    if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.has_position = rsp_ch.has_position;
      got.x = rsp_ch.out_x;
      got.y = rsp_ch.out_y;
      got.z = rsp_ch.out_z;
      sb.check_result(got);
    end
  end

  function automatic logic [POS_W-1:0] random_pos();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_item_t make_push(logic [TIME_W-1:0] t);
    req_item_t it;
    it.func       = tsi_pkg::FUNC_PUSH;
    it.snap_time  = t;
    it.pos_x      = random_pos();
    it.pos_y      = random_pos();
    it.pos_z      = random_pos();
    it.local_time = $urandom;
    return it;
  endfunction

  function automatic req_item_t make_query(logic [TIME_W-1:0] now);
    req_item_t it;
    it.func       = tsi_pkg::FUNC_QUERY;
    it.snap_time  = $urandom;
    it.pos_x      = $urandom;
    it.pos_y      = $urandom;
    it.pos_z      = $urandom;
    it.local_time = now;
    return it;
  endfunction

  // Holds an item on the request channel until it is taken.
  task automatic send_item(input req_item_t it);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= it.func;
    req_ch.snap_time  <= it.snap_time;
    req_ch.pos_x      <= it.pos_x;
    req_ch.pos_y      <= it.pos_y;
    req_ch.pos_z      <= it.pos_z;
    req_ch.local_time <= it.local_time;
    do begin
      @(posedge clk);
    end while (req_ch.ready !== 1'b1);
    sb.note_item(it);
  endtask

  // Sends in bursts of random length separated by random gaps.
  task automatic issue(input req_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_item(it);
    n_items++;
  endtask

  // Stops sending and waits until every query has been answered.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pos.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // Writes both registers; upper data bits above the span width are random.
  task automatic load_regs(input logic [DELAY_W-1:0] delay, input logic [SPAN_W-1:0] span);
    logic [CFG_DATA_W-1:0] span_data;
    span_data = {4'($urandom), span};
    cfg_we    <= 1'b1;
    cfg_index <= tsi_pkg::REG_INTERP_DELAY;
    cfg_data  <= CFG_DATA_W'(delay);
    sb.write_reg(tsi_pkg::REG_INTERP_DELAY, CFG_DATA_W'(delay));
    @(posedge clk);
    cfg_index <= tsi_pkg::REG_MIN_SPAN;
    cfg_data  <= span_data;
    sb.write_reg(tsi_pkg::REG_MIN_SPAN, span_data);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Mostly push groups in time order followed by queries aimed at the ring,
  // with a share of out-of-order pushes and wild local times.
  task automatic run_phase(input int n);
    int done, k, m, sel, pick;
    longint ta, tb, target, want, newest_t;
    logic [TIME_W-1:0] now;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 99) < 80) begin
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
        for (int j = 0; j < k; j++) begin
          sel = $urandom_range(0, 99);
          if (sel < 10) begin
            srv_clk = srv_clk;
          end else if (sel < 35) begin
            srv_clk = srv_clk + $urandom_range(1, 300);
          end else begin
            srv_clk = srv_clk + $urandom_range(1000, 150000);
          end
          issue(make_push(TIME_W'(srv_clk)));
          done++;
        end
        m = $urandom_range(1, 4);
        for (int j = 0; j < m; j++) begin
          loc_clk = loc_clk + $urandom_range(0, 40000);
          now = TIME_W'(loc_clk);
          // Where the tracked time will not move, pick local time to land
          // the render time on a chosen pair.
          if (sb.count >= 2) begin
            newest_t = sb.snap_t[sb.ring_slot(sb.count - 1)];
            if (newest_t <= longint'(sb.latest)) begin
              pick = $urandom_range(0, sb.count - 2);
              ta = sb.snap_t[sb.ring_slot(pick)];
              tb = sb.snap_t[sb.ring_slot(pick + 1)];
              sel = $urandom_range(0, 9);
              if (sel == 0) begin
                target = ta;
              end else if (sel == 1) begin
                target = tb;
              end else if (sel == 2) begin
                target = ta - longint'($urandom_range(1, 1000));
              end else if (tb > ta) begin
                target = ta + longint'($urandom_range(0, 32'(tb - ta)));
              end else begin
                target = ta;
              end
              want = target + longint'(sb.delay_reg) - longint'(sb.latest)
                     + longint'(sb.arrival);
              if (want >= 0 && want <= TIME_TOP) begin
                now = TIME_W'(want);
              end
            end
          end
          issue(make_query(now));
          done++;
        end
      end else if ($urandom_range(0, 1) == 0) begin
        issue(make_push($urandom_range(0, 32'(srv_clk))));
        done++;
      end else begin
        issue(make_query($urandom));
        done++;
      end
    end
  endtask

  initial begin : stimulus
    req_item_t it;
    logic [TIME_W-1:0] l1;
    logic [TIME_W-1:0] dir_times [7];
    dir_times = '{32'd3000, 32'd3000, 32'd3100, 32'd3200, 32'd3300, 32'd3400, 32'd3500};
    l1 = 32'h8000_0000;

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = tsi_pkg::REG_INTERP_DELAY;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.func       = tsi_pkg::FUNC_PUSH;
    req_ch.snap_time  = '0;
    req_ch.pos_x      = '0;
    req_ch.pos_y      = '0;
    req_ch.pos_z      = '0;
    req_ch.local_time = '0;
    rsp_ch.ready      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty ring, then a single snapshot.
    issue(make_query(32'd0));
    it = make_push(32'd1000);
    it.pos_x = 32'h7FFF_FFFF;
    it.pos_y = 32'h8000_0000;
    it.pos_z = '0;
    issue(it);
    issue(make_query(32'hFFFF_FFFF));

    // Largest timestamp followed by an older one, out of order.
    it = make_push(32'hFFFF_FFFF);
    it.pos_x = 32'hFFFF_FFFF;
    it.pos_y = 32'h0000_0001;
    it.pos_z = 32'h1234_5678;
    issue(it);
    it = make_push(32'd2000);
    it.pos_x = 32'h8000_0000;
    it.pos_y = 32'h7FFF_FFFF;
    it.pos_z = 32'hFFFF_FFFB;
    issue(it);

    // Newer server time is tracked; default delay puts render below zero.
    issue(make_query(32'd0));
    drain_results();
    load_regs(20'd0, 16'd100);

    // Render inside the wide out-of-order pair, then past the newest.
    issue(make_query(32'h4000_0000));
    issue(make_query(32'hFFFF_FFFF));

    // Fill the ring past its depth so the two oldest entries fall out.
    for (int k = 0; k < 7; k++) begin
      it = make_push(dir_times[k]);
      if (k == 0) begin
        it.pos_x = 32'h7FFF_FFFF;
        it.pos_y = 32'h8000_0000;
        it.pos_z = 32'h0000_0007;
      end
      issue(it);
    end

    // Bracket ends, midpoint with full-range steps, short span, negative render.
    issue(make_query(l1));
    issue(make_query(l1 - 32'd1500));
    issue(make_query(l1 - 32'd1000));
    issue(make_query(l1 - 32'd450));
    issue(make_query(32'd0));
    drain_results();

    srv_clk = 64'd4000;
    loc_clk = 64'h4000_0000;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       load_regs(20'd0, 16'd0);
        1:       load_regs(20'd1000000, 16'd65535);
        2:       load_regs(20'hFFFFF, 16'd100);
        3:       load_regs(20'd30000, 16'd0);
        default: load_regs(DELAY_W'($urandom_range(0, 400000)),
                           SPAN_W'($urandom_range(0, 2000)));
      endcase
      run_phase(255);
      drain_results();
    end

    $display("Run covered %0d items: %0d pushes, %0d queries, %0d register settings.",
             n_items, sb.n_push, sb.n_query, n_settings);
    $display("Queries: %0d interpolated (%0d at full fraction by span), %0d newest, %0d short.",
             sb.n_mixed, sb.n_span_one, sb.n_newest, sb.n_short);
    if (sb.errors == 0 && sb.expected_pos.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("Run timed out with %0d responses outstanding.", sb.expected_pos.size());
    $display("simulation failed");
    $finish;
  end

endmodule
